/* rtl/tre_pkg.sv */
package tre_pkg;

	localparam int RISK_W = 48;
	localparam int GAMMA_W = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] MODE_WORST = 2'd0;
	localparam logic [1:0] MODE_VAR = 2'd1;
	localparam logic [1:0] MODE_TCE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RISK_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd1;

	localparam logic [GAMMA_W-1:0] ONE_Q16 = 17'd65536;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_KCALC = 9'b000000010,
		S_CRD   = 9'b000000100,
		S_CLD   = 9'b000001000,
		S_SCAN  = 9'b000010000,
		S_DRAIN = 9'b000100000,
		S_CHECK = 9'b001000000,
		S_MUL   = 9'b010000000,
		S_DIV   = 9'b100000000
	} state_t;

endpackage

/* rtl/tre_ram.sv */
module tre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/tre_div.sv */
module tre_div #(
	parameter int NW = 81,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int NCW = $clog2(NW + 1);

	logic [NW-1:0]  num_q;
	logic [DW-1:0]  den_q;
	logic [DW-1:0]  rem_q;
	logic [NCW-1:0] cnt_q;
	logic           run_q;
	logic [DW:0]    rem_sh;
	logic           fits;

	// Restoring division: one quotient bit per cycle, most significant first.
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign fits = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == NCW'(NW - 1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= fits ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			quotient <= {quotient[NW-2:0], fits};
		end
	end

endmodule

/* rtl/tail_risk_impact_evaluator_core.sv */
// Scenario items are taken one per cycle while busy is low; each stores the smaller of its two
// impacts in the scenario memory unless the memory is full. The item marked last raises busy and
// starts the evaluation, which runs through the single read port of that memory: the worst-case
// mode makes one sweep over the stored set, the quantile mode sweeps candidates against the whole
// set, and the tail mean adds a shift-and-add multiply and a restoring division. The result appears
// on risk_value and overflow in the cycle that done is high, a one-cycle strobe that the receiver
// cannot stall; busy falls in that same cycle, so the next item may be given at once.
module tail_risk_impact_evaluator_core #(
	parameter int MAX_SCENARIOS = 1024,
	parameter int IMPACT_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [31:0]                    new_impact,
	input  logic [31:0]                    current_impact,
	input  logic                           last,
	output logic                           done,
	output logic [tre_pkg::RISK_W-1:0]     risk_value,
	output logic                           overflow,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tre_pkg::GAMMA_W-1:0]    cfg_data
);

	import tre_pkg::*;

	localparam int AW = $clog2(MAX_SCENARIOS);
	localparam int CW = $clog2(MAX_SCENARIOS + 1);
	localparam int IW = IMPACT_BITS;
	localparam int SW = IW + CW;
	localparam int QW = SW + 16;
	localparam int PW = CW + GAMMA_W;

	state_t state_q;

	logic [1:0]         mode_q;
	logic [GAMMA_W-1:0] gamma_q;
	logic [CW-1:0]      count_q;
	logic               ovf_seen_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      m_q;
	logic               ovf_set_q;
	logic [CW-1:0]      ci_q;
	logic [CW-1:0]      j_q;
	logic               rvalid_s1;
	logic [IW-1:0]      cand_q;
	logic [IW-1:0]      max_q;
	logic [CW-1:0]      lt_q;
	logic [CW-1:0]      le_q;
	logic [SW-1:0]      acc_q;
	logic [SW-1:0]      xsh_q;
	logic [CW-1:0]      mc_q;

	logic [31:0]   mn;
	logic [IW-1:0] v;
	logic          full;
	logic          accept;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [IW-1:0] ram_rdata;
	logic          div_start;
	logic          div_done;
	logic [QW-1:0] quo;

	logic [GAMMA_W-1:0] g_cl;
	logic [GAMMA_W-1:0] omg;
	logic [PW-1:0]      prod;
	logic [PW-1:0]      kk;
	logic               found;
	logic               stat_mode;
	logic [IW+47:0]     cand_ext;
	logic [IW+47:0]     max_ext;
	logic [QW+47:0]     quo_ext;
	logic [RISK_W-1:0]  cand_q16;
	logic [RISK_W-1:0]  max_q16;
	logic [RISK_W-1:0]  quo_sat;

	assign mn = (new_impact < current_impact) ? new_impact : current_impact;

	generate
		if (IW < 32) begin : g_sat
			assign v = (|mn[31:IW]) ? {IW{1'b1}} : mn[IW-1:0];
		end else begin : g_ext
			assign v = IW'(mn);
		end
	endgenerate

	assign busy = state_q != S_IDLE;
	assign accept = start && !busy;
	assign full = count_q == CW'(MAX_SCENARIOS);
	assign cfg_ready = 1'b1;

	assign g_cl = (gamma_q > ONE_Q16) ? ONE_Q16 : gamma_q;
	assign omg = ONE_Q16 - g_cl;
	assign prod = PW'(n_q) * PW'(omg);
	assign kk = (prod + PW'(16'hFFFF)) >> 16;

	assign stat_mode = (mode_q == MODE_VAR) || (mode_q == MODE_TCE);
	assign found = (lt_q < k_q) && (k_q <= le_q);

	// Values wider than 32 integer bits saturate once placed in Q32.16.
	assign cand_ext = (IW + 48)'(cand_q);
	assign max_ext = (IW + 48)'(max_q);
	assign quo_ext = (QW + 48)'(quo);
	assign cand_q16 = (|cand_ext[IW+47:32]) ? {RISK_W{1'b1}} : {cand_ext[31:0], 16'd0};
	assign max_q16 = (|max_ext[IW+47:32]) ? {RISK_W{1'b1}} : {max_ext[31:0], 16'd0};
	assign quo_sat = (|quo_ext[QW+47:48]) ? {RISK_W{1'b1}} : quo_ext[47:0];

	assign ram_re = (state_q == S_CRD) || (state_q == S_SCAN);
	assign ram_raddr = (state_q == S_CRD) ? ci_q[AW-1:0] : j_q[AW-1:0];
	assign div_start = (state_q == S_MUL) && (mc_q == '0);

	tre_ram #(
		.WIDTH(IW),
		.DEPTH(MAX_SCENARIOS)
	) u_store (
		.clk  (clk),
		.we   (accept && !full),
		.waddr(count_q[AW-1:0]),
		.wdata(v),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tre_div #(
		.NW(QW),
		.DW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({acc_q, 16'd0}),
		.divisor (m_q),
		.done    (div_done),
		.quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WORST;
			gamma_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RISK_MODE: mode_q <= cfg_data[1:0];
				CFG_GAMMA: gamma_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_seen_q <= 1'b0;
			done <= 1'b0;
			rvalid_s1 <= 1'b0;
		end else begin
			done <= 1'b0;
			rvalid_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (last) begin
							count_q <= '0;
							ovf_seen_q <= 1'b0;
							state_q <= S_KCALC;
						end else if (full) begin
							ovf_seen_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_KCALC: state_q <= S_CRD;
				S_CRD: state_q <= S_CLD;
				S_CLD: state_q <= S_SCAN;
				S_SCAN: begin
					rvalid_s1 <= 1'b1;
					if (j_q == n_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_CHECK;
				S_CHECK: begin
					if (!stat_mode || (found && mode_q == MODE_VAR)) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (found) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_CRD;
					end
				end
				S_MUL: begin
					if (mc_q == '0) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept && last) begin
					n_q <= full ? count_q : count_q + 1'b1;
					ovf_set_q <= ovf_seen_q || full;
				end
				ci_q <= '0;
			end
			S_KCALC: begin
				if (kk == '0) begin
					k_q <= CW'(1);
				end else if (kk > PW'(n_q)) begin
					k_q <= n_q;
				end else begin
					k_q <= kk[CW-1:0];
				end
			end
			S_CLD: begin
				cand_q <= ram_rdata;
				j_q <= '0;
				lt_q <= '0;
				le_q <= '0;
				acc_q <= '0;
				max_q <= '0;
			end
			S_SCAN: j_q <= j_q + 1'b1;
			S_CHECK: begin
				if (!stat_mode) begin
					risk_value <= max_q16;
					overflow <= ovf_set_q;
				end else if (found && mode_q == MODE_VAR) begin
					risk_value <= cand_q16;
					overflow <= ovf_set_q;
				end else if (found) begin
					// Tail sum: values above the quantile plus its ties inside the tail.
					mc_q <= le_q - k_q + 1'b1;
					m_q <= n_q - k_q + 1'b1;
					xsh_q <= SW'(cand_q);
				end else begin
					ci_q <= ci_q + 1'b1;
				end
			end
			S_MUL: begin
				if (mc_q != '0) begin
					if (mc_q[0]) begin
						acc_q <= acc_q + xsh_q;
					end
					xsh_q <= {xsh_q[SW-2:0], 1'b0};
					mc_q <= mc_q >> 1;
				end
			end
			S_DIV: begin
				if (div_done) begin
					risk_value <= quo_sat;
					overflow <= ovf_set_q;
				end
			end
			default: ;
		endcase
		if (rvalid_s1) begin
			if (ram_rdata < cand_q) begin
				lt_q <= lt_q + 1'b1;
			end
			if (ram_rdata <= cand_q) begin
				le_q <= le_q + 1'b1;
			end else begin
				acc_q <= acc_q + SW'(ram_rdata);
			end
			if (ram_rdata > max_q) begin
				max_q <= ram_rdata;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SCENARIOS))
		else $error("stored item count beyond the memory depth");

	a_busy_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last))
		else $error("evaluation started without a last item");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of an evaluation");

	a_scan_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> lt_q <= le_q && le_q <= n_q)
		else $error("rank counts inconsistent after a scan");

endmodule
